[design/weighted_rgb_tap_normalizer_unit_macros.svh]
// Assertion macros shared by the checker of the tap normalizer.
// No dependencies; include by bare file name.
`ifndef WEIGHTED_RGB_TAP_NORMALIZER_UNIT_MACROS_SVH
`define WEIGHTED_RGB_TAP_NORMALIZER_UNIT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define WRTN_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define WRTN_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/wrtn_pkg.sv]
// Shared types and constants of the weighted RGB tap normalizer.
// No dependencies.
`default_nettype none
package wrtn_pkg;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned SUM_W    = 32;
	localparam int unsigned NUM_CHAN = 3;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 24;
	// Quotient bits produced by the divider: eight result bits and one overflow bit.
	localparam int unsigned QUOT_W = CHAN_W + 1;
	localparam int unsigned DIVISOR_W = SUM_W + CHAN_W;
	localparam int unsigned STEP_W = 4;

	typedef struct packed {
		logic [SUM_W-1:0]               weight;
		logic [NUM_CHAN-1:0][SUM_W-1:0] chan;
	} sums_t;

	typedef struct packed {
		logic take;
	} acc_cmd_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_cmd_t;

	function automatic logic [SUM_W-1:0] abs_sum(input logic [SUM_W-1:0] v);
		return v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
	endfunction
endpackage
`default_nettype wire

[design/wrtn_accum.sv]
// Tap accumulator: running weight and weighted color sums, tap counter and the
// hand-off register of closed sums. Depends on wrtn_pkg.
`default_nettype none
module wrtn_accum import wrtn_pkg::*; #(
	parameter int unsigned MAX_TAPS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire acc_cmd_t             cmd,
	input  wire logic [WEIGHT_W-1:0]  tap_weight,
	input  wire logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel,
	input  wire logic                 last_tap,
	output logic                      closing,
	output sums_t                     snap
);
	localparam int unsigned CNT_W = $clog2(MAX_TAPS + 1);

	sums_t            total_q;
	sums_t            next_total;
	sums_t            snap_q;
	logic [CNT_W-1:0] tap_cnt_q;
	logic signed [WEIGHT_W+CHAN_W:0] prod [NUM_CHAN];

	always_comb begin
		next_total.weight = total_q.weight
			+ SUM_W'($signed({{(SUM_W-WEIGHT_W){tap_weight[WEIGHT_W-1]}}, tap_weight}));
		for (int i = 0; i < NUM_CHAN; i++) begin
			prod[i] = $signed(tap_weight) * $signed({1'b0, pixel[i]});
			next_total.chan[i] = total_q.chan[i]
				+ {{(SUM_W-WEIGHT_W-CHAN_W-1){prod[i][WEIGHT_W+CHAN_W]}}, prod[i]};
		end
	end

	// A pixel also closes on its last allowed tap.
	assign closing = last_tap || (tap_cnt_q == CNT_W'(MAX_TAPS - 1));
	assign snap = snap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			tap_cnt_q <= '0;
		end else if (cmd.take) begin
			if (closing) begin
				total_q   <= '0;
				tap_cnt_q <= '0;
			end else begin
				total_q   <= next_total;
				tap_cnt_q <= tap_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && closing) begin
			snap_q <= next_total;
		end
	end
endmodule
`default_nettype wire

[design/wrtn_div.sv]
// Divide and clamp datapath: three restoring dividers that share one shifted
// divisor, one quotient bit per step. Depends on wrtn_pkg.
`default_nettype none
module wrtn_div import wrtn_pkg::*; (
	input  wire logic  clk,
	input  wire div_cmd_t cmd,
	input  wire sums_t snap,
	output logic [NUM_CHAN-1:0][CHAN_W-1:0] color,
	output logic       zero_sum
);
	logic [DIVISOR_W-1:0] div_q;
	logic                 zero_q;
	logic [SUM_W-1:0]     rem_q  [NUM_CHAN];
	logic [QUOT_W-1:0]    quot_q [NUM_CHAN];
	logic                 clip_q [NUM_CHAN];
	logic                 ge     [NUM_CHAN];

	always_comb begin
		for (int i = 0; i < NUM_CHAN; i++) begin
			ge[i] = {{CHAN_W{1'b0}}, rem_q[i]} >= div_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zero_q <= (snap.weight == '0);
			div_q  <= {abs_sum(snap.weight), {CHAN_W{1'b0}}};
			for (int i = 0; i < NUM_CHAN; i++) begin
				// Opposite signs or a zero numerator give a quotient at or below zero.
				clip_q[i] <= (snap.chan[i] == '0)
					|| (snap.chan[i][SUM_W-1] != snap.weight[SUM_W-1]);
				rem_q[i]  <= abs_sum(snap.chan[i]);
				quot_q[i] <= '0;
			end
		end else if (cmd.step) begin
			div_q <= div_q >> 1;
			for (int i = 0; i < NUM_CHAN; i++) begin
				if (ge[i]) begin
					rem_q[i] <= rem_q[i] - div_q[SUM_W-1:0];
				end
				quot_q[i] <= {quot_q[i][QUOT_W-2:0], ge[i]};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_CHAN; i++) begin
			if (zero_q || clip_q[i]) begin
				color[i] = '0;
			end else if (quot_q[i][QUOT_W-1]) begin
				color[i] = '1;
			end else begin
				color[i] = quot_q[i][CHAN_W-1:0];
			end
		end
	end
	assign zero_sum = zero_q;
endmodule
`default_nettype wire

[design/wrtn_ctrl.sv]
// Controller: input handshake, hand-off flag of closed sums, divider
// sequencing and output valid. Depends on wrtn_pkg.
`default_nettype none
module wrtn_ctrl import wrtn_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic closing,
	output acc_cmd_t  acc_cmd,
	output div_cmd_t  div_cmd,
	output logic      out_valid,
	input  wire logic out_ready
);
	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              snap_valid_q;
	logic              out_valid_q;

	assign div_cmd.load = (state_q == ST_IDLE) && snap_valid_q;
	assign div_cmd.step = (state_q == ST_RUN);
	// The hand-off register frees up in the same cycle the divider loads it.
	assign in_ready     = !snap_valid_q || div_cmd.load;
	assign acc_cmd.take = in_valid && in_ready;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			snap_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (acc_cmd.take && closing) begin
				snap_valid_q <= 1'b1;
			end else if (div_cmd.load) begin
				snap_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (snap_valid_q) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(QUOT_W - 1)) begin
						state_q     <= ST_HOLD;
						out_valid_q <= 1'b1;
					end
				end
				ST_HOLD: begin
					if (out_ready) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[design/weighted_rgb_tap_normalizer_unit.sv]
// Weighted RGB tap normalizer, the back end of a resampling scaler. Taps stream
// in one word per cycle; each adds its weight and weight times red, green and
// blue to 32-bit wrapping sums. A tap with tlast set, or the MAX_TAPS-th tap of
// a pixel, closes the pixel: its sums move to a hand-off register and the next
// pixel starts accumulating at once. Three restoring dividers sharing one
// divisor then form the three quotients one bit per cycle, truncating toward
// zero and clamping to 0..255; a zero weight sum yields black with tuser set.
// Once free, the divider loads the closed sums, steps through all quotient bits
// and raises the result word, which holds until taken. Input runs at one tap
// per cycle as long as pixels have at least eleven taps and results are taken
// at once. Otherwise a closed pixel may have to wait in the hand-off
// register for the busy divider, and while it waits every further tap is
// held off, so the divider sets the pixel rate. Depends on wrtn_pkg.
`default_nettype none
module weighted_rgb_tap_normalizer_unit import wrtn_pkg::*; #(
	parameter int unsigned MAX_TAPS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// tap_weight[15:0], pixel_red[23:16], pixel_green[31:24], pixel_blue[39:32]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic                  s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// zero_sum[0]
	output logic                       m_axis_tuser
);
	acc_cmd_t acc_cmd;
	div_cmd_t div_cmd;
	logic     closing;
	sums_t    snap;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] color;

	assign pixel = s_axis_tdata[IN_DATA_W-1:WEIGHT_W];
	assign m_axis_tdata = color;

	wrtn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.closing   (closing),
		.acc_cmd   (acc_cmd),
		.div_cmd   (div_cmd),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	wrtn_accum #(
		.MAX_TAPS (MAX_TAPS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (acc_cmd),
		.tap_weight (s_axis_tdata[WEIGHT_W-1:0]),
		.pixel      (pixel),
		.last_tap   (s_axis_tlast),
		.closing    (closing),
		.snap       (snap)
	);

	wrtn_div u_div (
		.clk      (clk),
		.cmd      (div_cmd),
		.snap     (snap),
		.color    (color),
		.zero_sum (m_axis_tuser)
	);
endmodule
`default_nettype wire

[design/wrtn_checker.sv]
// Port-level checker of the tap normalizer and its bind to the top level.
// Depends on wrtn_pkg and weighted_rgb_tap_normalizer_unit_macros.svh.
`default_nettype none
`include "weighted_rgb_tap_normalizer_unit_macros.svh"
module wrtn_checker import wrtn_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input wire logic                  s_axis_tlast,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tuser
);
	`WRTN_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
	`WRTN_ASSERT(a_zero_black, clk, arst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "zero weight sum without black pixel")
	`WRTN_ASSERT(a_out_gap, clk, arst_n, m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid, "result word repeated after being taken")
	`WRTN_ASSERT(a_in_hold, clk, arst_n, s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast), "input word changed while stalled")
	`WRTN_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !m_axis_tvalid, "result word valid during reset")
endmodule

bind weighted_rgb_tap_normalizer_unit wrtn_checker u_checker (.*);
`default_nettype wire

[tb/sv/tb_weighted_rgb_tap_normalizer_unit.sv]
// Testbench for weighted_rgb_tap_normalizer_unit: streams filter taps in and checks
// every normalized pixel against a predictor of the running weighted sums.
// Depends on wrtn_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_weighted_rgb_tap_normalizer_unit;
	import wrtn_pkg::*;

	localparam int unsigned TAP_LIMIT = 64;
	localparam int DRAIN_CYCLES = 32;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              zero_sum;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// tap_weight[15:0], pixel_red[23:16], pixel_green[31:24], pixel_blue[39:32]
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// out_red[7:0], out_green[15:8], out_blue[23:16]
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// zero_sum[0]
	logic                  m_axis_tuser;

	// Predicted pixel state, mirrors the unit's accumulators.
	logic [SUM_W-1:0] weight_sum = '0;
	logic [SUM_W-1:0] red_sum = '0;
	logic [SUM_W-1:0] green_sum = '0;
	logic [SUM_W-1:0] blue_sum = '0;
	int unsigned      taps_in_pixel = 0;

	pixel_t pixels_expected[$];
	int     mismatches = 0;
	int     taps_sent = 0;
	bit     idle_on = 1'b1;
	int     stall_left = 0;

	weighted_rgb_tap_normalizer_unit #(
		.MAX_TAPS(TAP_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [CHAN_W-1:0] normalize_channel(input logic [SUM_W-1:0] chan,
			input logic [SUM_W-1:0] den);
		longint quot;
		// Exact 64-bit quotient, truncated toward zero, then clamped.
		quot = longint'($signed(chan)) / longint'($signed(den));
		if (quot < 0)
			return '0;
		if (quot > 255)
			return 8'd255;
		return quot[CHAN_W-1:0];
	endfunction

	task automatic accumulate_tap(input logic [IN_DATA_W-1:0] word, input logic last);
		int     weight;
		pixel_t px;
		weight = int'($signed(word[15:0]));
		weight_sum += SUM_W'(weight);
		red_sum += SUM_W'(weight * int'(word[23:16]));
		green_sum += SUM_W'(weight * int'(word[31:24]));
		blue_sum += SUM_W'(weight * int'(word[39:32]));
		taps_in_pixel++;
		if (last || taps_in_pixel >= TAP_LIMIT) begin
			if (weight_sum == '0) begin
				px = '{red: '0, green: '0, blue: '0, zero_sum: 1'b1};
			end else begin
				px.red = normalize_channel(red_sum, weight_sum);
				px.green = normalize_channel(green_sum, weight_sum);
				px.blue = normalize_channel(blue_sum, weight_sum);
				px.zero_sum = 1'b0;
			end
			pixels_expected.push_back(px);
			weight_sum = '0;
			red_sum = '0;
			green_sum = '0;
			blue_sum = '0;
			taps_in_pixel = 0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			accumulate_tap(s_axis_tdata, s_axis_tlast);
	end

	always @(posedge clk) begin
		pixel_t want;
		pixel_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{red: m_axis_tdata[7:0], green: m_axis_tdata[15:8],
				blue: m_axis_tdata[23:16], zero_sum: m_axis_tuser};
			if (pixels_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel word r=%0d g=%0d b=%0d zero=%0d",
						got.red, got.green, got.blue, got.zero_sum);
			end else begin
				want = pixels_expected.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel mismatch: expected r=%0d g=%0d b=%0d zero=%0d, got r=%0d g=%0d b=%0d zero=%0d",
							want.red, want.green, want.blue, want.zero_sum,
							got.red, got.green, got.blue, got.zero_sum);
				end
			end
		end
	end

	// Receiver stalls come in bursts of random length.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(0, 17);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_tap(input logic [WEIGHT_W-1:0] weight, input logic [CHAN_W-1:0] red,
			input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue, input logic last);
		int gap;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 18);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {blue, green, red, weight};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		taps_sent++;
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pixels_expected.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CHAN_W-1:0] pick_channel();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return 8'd255;
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	// A smooth pixel has kernel-like weights that mostly sum positive; otherwise
	// the weights cover the full signed range.
	task automatic send_pixel(input int taps, input bit smooth);
		logic [WEIGHT_W-1:0] weight;
		for (int i = 0; i < taps; i++) begin
			if (smooth)
				weight = WEIGHT_W'(int'($urandom_range(0, 700)) - 100);
			else
				weight = WEIGHT_W'($urandom);
			send_tap(weight, pick_channel(), pick_channel(), pick_channel(), i == taps - 1);
		end
	endtask

	task automatic send_balanced_pixel(input int pairs);
		logic [WEIGHT_W-1:0] weight;
		for (int i = 0; i < pairs; i++) begin
			weight = WEIGHT_W'($urandom);
			send_tap(weight, pick_channel(), pick_channel(), pick_channel(), 1'b0);
			send_tap(-weight, pick_channel(), pick_channel(), pick_channel(), i == pairs - 1);
		end
	endtask

	task automatic test_single_taps();
		send_tap(16'sd32767, 8'd255, 8'd0, 8'd128, 1'b1);
		send_tap(-16'sd32768, 8'd255, 8'd0, 8'd1, 1'b1);
		send_tap(16'sd1, 8'd0, 8'd255, 8'd17, 1'b1);
		send_tap(-16'sd1, 8'd255, 8'd0, 8'd200, 1'b1);
	endtask

	task automatic test_zero_weight_sum();
		send_tap(16'sd0, 8'd255, 8'd255, 8'd255, 1'b1);
		send_tap(16'sd1000, 8'd10, 8'd20, 8'd30, 1'b0);
		send_tap(-16'sd1000, 8'd200, 8'd100, 8'd0, 1'b1);
	endtask

	task automatic test_clamp_and_truncation();
		// Weight sum of -1 turns the largest sums into quotients far out of range.
		send_tap(16'sd32767, 8'd255, 8'd255, 8'd0, 1'b0);
		send_tap(-16'sd32768, 8'd0, 8'd255, 8'd255, 1'b1);
		send_tap(-16'sd32768, 8'd255, 8'd0, 8'd0, 1'b0);
		send_tap(16'sd32767, 8'd0, 8'd0, 8'd255, 1'b1);
		send_tap(16'sd2, 8'd255, 8'd0, 8'd100, 1'b0);
		send_tap(-16'sd1, 8'd0, 8'd255, 8'd3, 1'b1);
		send_tap(16'sd3, 8'd10, 8'd11, 8'd0, 1'b0);
		send_tap(16'sd4, 8'd0, 8'd0, 8'd255, 1'b1);
		send_tap(-16'sd3, 8'd10, 8'd11, 8'd0, 1'b0);
		send_tap(-16'sd4, 8'd0, 8'd0, 8'd255, 1'b1);
	endtask

	task automatic test_tap_limit();
		// No tlast at all: the unit must close the pixel on its own.
		for (int i = 0; i < TAP_LIMIT; i++)
			send_tap(WEIGHT_W'(i + 1), CHAN_W'(i * 4), CHAN_W'(255 - i), CHAN_W'(i), 1'b0);
		send_tap(16'sd5, 8'd50, 8'd60, 8'd70, 1'b1);
		// The overflow taps past the limit form a new pixel.
		send_pixel(TAP_LIMIT + 6, 1'b1);
	endtask

	task automatic test_random_pixels(input int tap_goal);
		int start;
		int roll;
		start = taps_sent;
		while (taps_sent - start < tap_goal) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				send_pixel($urandom_range(1, 12), 1'b1);
			else if (roll < 80)
				send_pixel($urandom_range(1, 12), 1'b0);
			else if (roll < 88)
				send_pixel($urandom_range(13, 40), 1'b1);
			else if (roll < 93)
				send_pixel($urandom_range(60, 70), $urandom_range(0, 1));
			else
				send_balanced_pixel($urandom_range(1, 4));
		end
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 3; i++) begin
			test_random_pixels(40);
			wait_for_results();
		end
	endtask

	task automatic test_back_to_back();
		int start;
		idle_on = 1'b0;
		start = taps_sent;
		// Short pixels keep the divider busy without any gaps.
		while (taps_sent - start < 250)
			send_pixel($urandom_range(1, 3), $urandom_range(0, 3) != 0);
		test_random_pixels(100);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_taps();
		test_zero_weight_sum();
		test_clamp_and_truncation();
		test_tap_limit();
		test_drain_pause();
		test_random_pixels(900);
		test_back_to_back();
		wait_for_results();
		if (mismatches == 0 && pixels_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

[weighted_rgb_tap_normalizer_unit.f]
+incdir+design
design/wrtn_pkg.sv
design/wrtn_accum.sv
design/wrtn_div.sv
design/wrtn_ctrl.sv
design/weighted_rgb_tap_normalizer_unit.sv
design/wrtn_checker.sv
tb/sv/tb_weighted_rgb_tap_normalizer_unit.sv
